// ===== design/rsc_pkg.sv =====
// Shared types and constants for the radix integer scanner.
package rsc_pkg;

    localparam int unsigned MAX_SPAN_DEFAULT = 65535;

    localparam int CHAR_W   = 8;
    localparam int RADIX_W  = 6;
    localparam int DIGIT_W  = 6;
    localparam int ACC_W    = 64;
    localparam int CNT_W    = 16;
    localparam int SPAN_W   = 16;
    localparam int STATUS_W = 3;
    localparam int NTYPE_W  = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] ALPHA_BASE  = 6'd10;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

    typedef enum logic [NTYPE_W-1:0] {
        NT_INT64  = 2'd0,
        NT_INT32  = 2'd1,
        NT_UINT64 = 2'd2,
        NT_UINT32 = 2'd3
    } num_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_RADIX = 3'd1,
        ST_NO_DIGITS = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_START  = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    typedef enum logic [0:0] {
        REG_RADIX    = 1'b0,
        REG_NUM_TYPE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic is_digit;
        logic carry;
    } mac_flags_t;

endpackage

// ===== design/radix_integer_scanner.sv =====
// Top level: byte-stream integer parser with APB configuration.
//
// channel  | dir | handshake              | payload
// input    | in  | in_valid / in_ready    | char_code, first, last
// result   | out | out_valid / out_ready  | value, negative, status, span_length
// config   | in  | APB psel/penable       | radix @0x0, number_type @0x4
//
// One byte per cycle sustained while the result register is not stalled; a byte is held in the input register, then the
// digit multiply-accumulate and end-of-number checks load the result register.
// Reset: radix 10, int64, no scan active, both registers empty.
// A stalled result beat holds the input register; bytes keep flowing while the
// result register is empty or being drained.
module radix_integer_scanner #(
    parameter int unsigned MAX_SPAN = rsc_pkg::MAX_SPAN_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsc_pkg::APB_AW-1:0]    paddr,
    input  logic [rsc_pkg::APB_DW-1:0]    pwdata,
    output logic [rsc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rsc_pkg::CHAR_W-1:0]    char_code,
    input  logic                          first,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rsc_pkg::ACC_W-1:0]     value,
    output logic                          negative,
    output logic [rsc_pkg::STATUS_W-1:0]  status,
    output logic [rsc_pkg::SPAN_W-1:0]    span_length
);

    localparam int SPAN_FULL_W = rsc_pkg::CNT_W + 1;
    localparam logic [SPAN_FULL_W-1:0] SPAN_CAP =
        (MAX_SPAN > 32'd65535) ? SPAN_FULL_W'(65535) : SPAN_FULL_W'(MAX_SPAN);
    localparam logic [rsc_pkg::CNT_W-1:0] CNT_SAT = '1;
    localparam logic [rsc_pkg::ACC_W-1:0] LIM_I64_POS = {1'b0, {(rsc_pkg::ACC_W-1){1'b1}}};
    localparam logic [rsc_pkg::ACC_W-1:0] LIM_I64_NEG = {1'b1, {(rsc_pkg::ACC_W-1){1'b0}}};
    localparam logic [rsc_pkg::ACC_W-1:0] LIM_I32_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [rsc_pkg::ACC_W-1:0] LIM_I32_NEG = 64'h0000_0000_8000_0000;
    localparam logic [rsc_pkg::ACC_W-1:0] LIM_U64     = '1;
    localparam logic [rsc_pkg::ACC_W-1:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;

    // configuration
    logic [rsc_pkg::RADIX_W-1:0] radix_reg;
    rsc_pkg::num_type_t          number_type_reg;
    logic                        cfg_wr;

    // input register
    logic                        in_valid_reg;
    logic [rsc_pkg::CHAR_W-1:0]  char_reg;
    logic                        first_reg;
    logic                        last_reg;

    // scan state
    logic [rsc_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [rsc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        minus_reg, minus_next;
    logic                        sign_reg, sign_next;
    logic                        ovf_reg, ovf_next;
    rsc_pkg::phase_t             phase_reg, phase_next;

    // result register
    logic                        out_valid_reg;
    logic [rsc_pkg::ACC_W-1:0]   value_reg, value_next;
    logic                        neg_reg, neg_next;
    rsc_pkg::status_t            status_reg, status_next;
    logic [rsc_pkg::SPAN_W-1:0]  span_reg, span_next;

    logic                        out_free;
    logic                        advance;
    logic                        emit;
    logic                        bad_radix;

    logic [rsc_pkg::ACC_W-1:0]   acc_eff;
    logic [rsc_pkg::CNT_W-1:0]   cnt_eff;
    logic                        minus_eff, sign_eff, ovf_eff;
    rsc_pkg::phase_t             phase_eff;

    logic [rsc_pkg::ACC_W-1:0]   mac_acc;
    rsc_pkg::mac_flags_t         mac_flags;

    logic                        radix_ok;
    logic                        signed_type;
    logic                        sign_char;
    logic [rsc_pkg::ACC_W-1:0]   limit;
    logic [SPAN_FULL_W-1:0]      span_full;
    logic [SPAN_FULL_W-1:0]      span_capped;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (rsc_pkg::reg_idx_t'(paddr[2]))
            rsc_pkg::REG_RADIX:    prdata = rsc_pkg::APB_DW'(radix_reg);
            rsc_pkg::REG_NUM_TYPE: prdata = rsc_pkg::APB_DW'(number_type_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= rsc_pkg::RADIX_RESET;
            number_type_reg <= rsc_pkg::NT_INT64;
        end
        else if (cfg_wr)
        begin
            case (rsc_pkg::reg_idx_t'(paddr[2]))
                rsc_pkg::REG_RADIX:    radix_reg <= pwdata[rsc_pkg::RADIX_W-1:0];
                rsc_pkg::REG_NUM_TYPE:
                    number_type_reg <= rsc_pkg::num_type_t'(pwdata[rsc_pkg::NTYPE_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg  <= char_code;
            first_reg <= first;
            last_reg  <= last;
        end
    end

    // ---------------- scan step ----------------
    assign acc_eff   = first_reg ? '0 : acc_reg;
    assign cnt_eff   = first_reg ? '0 : cnt_reg;
    assign minus_eff = first_reg ? 1'b0 : minus_reg;
    assign sign_eff  = first_reg ? 1'b0 : sign_reg;
    assign ovf_eff   = first_reg ? 1'b0 : ovf_reg;
    assign phase_eff = first_reg ? rsc_pkg::PH_START : phase_reg;

    rsc_digit_mac u_mac (
        .char_code (char_reg),
        .radix     (radix_reg),
        .acc       (acc_eff),
        .acc_next  (mac_acc),
        .flags     (mac_flags)
    );

    assign radix_ok    = (radix_reg >= rsc_pkg::RADIX_MIN) && (radix_reg <= rsc_pkg::RADIX_MAX);
    assign signed_type = (number_type_reg == rsc_pkg::NT_INT64) ||
                         (number_type_reg == rsc_pkg::NT_INT32);
    assign sign_char   = (char_reg == rsc_pkg::CH_MINUS) || (char_reg == rsc_pkg::CH_PLUS);

    always_comb
    begin
        acc_next   = acc_eff;
        cnt_next   = cnt_eff;
        minus_next = minus_eff;
        sign_next  = sign_eff;
        ovf_next   = ovf_eff;
        phase_next = phase_eff;
        emit       = 1'b0;
        bad_radix  = 1'b0;
        if (phase_eff != rsc_pkg::PH_IDLE)
        begin
            if (!radix_ok)
            begin
                emit      = 1'b1;
                bad_radix = 1'b1;
            end
            else if (phase_eff == rsc_pkg::PH_START && signed_type && sign_char)
            begin
                sign_next  = 1'b1;
                minus_next = (char_reg == rsc_pkg::CH_MINUS);
                phase_next = rsc_pkg::PH_DIGITS;
                emit       = last_reg;
            end
            else
            begin
                phase_next = rsc_pkg::PH_DIGITS;
                if (!mac_flags.is_digit)
                begin
                    // terminator: not consumed
                    emit = 1'b1;
                end
                else
                begin
                    if (mac_flags.carry)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mac_acc;
                    end
                    if (cnt_eff != CNT_SAT)
                    begin
                        cnt_next = cnt_eff + 1'b1;
                    end
                    emit = last_reg;
                end
            end
            if (emit)
            begin
                phase_next = rsc_pkg::PH_IDLE;
            end
        end
    end

    // ---------------- end of number ----------------
    always_comb
    begin
        case (number_type_reg)
            rsc_pkg::NT_INT64:  limit = minus_next ? LIM_I64_NEG : LIM_I64_POS;
            rsc_pkg::NT_INT32:  limit = minus_next ? LIM_I32_NEG : LIM_I32_POS;
            rsc_pkg::NT_UINT64: limit = LIM_U64;
            default:            limit = LIM_U32;
        endcase
    end

    assign span_full   = SPAN_FULL_W'(cnt_next) + SPAN_FULL_W'(sign_next);
    assign span_capped = (span_full > SPAN_CAP) ? SPAN_CAP : span_full;

    always_comb
    begin
        value_next  = '0;
        neg_next    = minus_next;
        span_next   = '0;
        if (bad_radix)
        begin
            status_next = rsc_pkg::ST_BAD_RADIX;
            neg_next    = 1'b0;
        end
        else if (cnt_next == '0)
        begin
            status_next = rsc_pkg::ST_NO_DIGITS;
        end
        else if (ovf_next)
        begin
            status_next = rsc_pkg::ST_OVERFLOW;
        end
        else if (acc_next > limit)
        begin
            status_next = rsc_pkg::ST_RANGE;
        end
        else
        begin
            status_next = rsc_pkg::ST_OK;
            value_next  = minus_next ? (~acc_next + 1'b1) : acc_next;
            span_next   = span_capped[rsc_pkg::SPAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            minus_reg <= 1'b0;
            sign_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            phase_reg <= rsc_pkg::PH_IDLE;
        end
        else if (advance)
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            minus_reg <= minus_next;
            sign_reg  <= sign_next;
            ovf_reg   <= ovf_next;
            phase_reg <= phase_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            value_reg  <= value_next;
            neg_reg    <= neg_next;
            status_reg <= status_next;
            span_reg   <= span_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign negative    = neg_reg;
    assign status      = status_reg;
    assign span_length = span_reg;

    // ---------------- assertions ----------------
    a_bad_radix_reported: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (phase_eff != rsc_pkg::PH_IDLE) && !radix_ok
        |=> out_valid_reg && (status_reg == rsc_pkg::ST_BAD_RADIX))
        else $error("bad radix not reported");

    a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != rsc_pkg::ST_OK) |-> (value_reg == '0) && (span_reg == '0))
        else $error("failed result carries value or span");

    a_ok_has_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == rsc_pkg::ST_OK) |-> (span_reg != '0))
        else $error("ok result with empty span");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

// ===== design/rsc_digit_mac.sv =====
// Digit decode and one multiply-accumulate step with 64-bit overflow detect.
module rsc_digit_mac (
    input  logic [rsc_pkg::CHAR_W-1:0]  char_code,
    input  logic [rsc_pkg::RADIX_W-1:0] radix,
    input  logic [rsc_pkg::ACC_W-1:0]   acc,
    output logic [rsc_pkg::ACC_W-1:0]   acc_next,
    output rsc_pkg::mac_flags_t         flags
);

    localparam int PROD_W = rsc_pkg::ACC_W + rsc_pkg::RADIX_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [rsc_pkg::DIGIT_W-1:0] digit;
    logic                        alnum;
    logic [PROD_W-1:0]           prod;
    logic [SUM_W-1:0]            sum;

    always_comb
    begin
        alnum = 1'b1;
        digit = '0;
        if (char_code >= rsc_pkg::CH_0 && char_code <= rsc_pkg::CH_9)
        begin
            digit = rsc_pkg::DIGIT_W'(char_code - rsc_pkg::CH_0);
        end
        else if (char_code >= rsc_pkg::CH_UP_A && char_code <= rsc_pkg::CH_UP_Z)
        begin
            digit = rsc_pkg::DIGIT_W'(char_code - rsc_pkg::CH_UP_A) + rsc_pkg::ALPHA_BASE;
        end
        else if (char_code >= rsc_pkg::CH_LO_A && char_code <= rsc_pkg::CH_LO_Z)
        begin
            digit = rsc_pkg::DIGIT_W'(char_code - rsc_pkg::CH_LO_A) + rsc_pkg::ALPHA_BASE;
        end
        else
        begin
            alnum = 1'b0;
        end
    end

    assign prod = PROD_W'(acc) * PROD_W'(radix);
    assign sum  = SUM_W'(prod) + SUM_W'(digit);

    assign acc_next       = sum[rsc_pkg::ACC_W-1:0];
    assign flags.is_digit = alnum && (digit < radix);
    assign flags.carry    = |sum[SUM_W-1:rsc_pkg::ACC_W];

endmodule
